// File: design/ddnc_pkg.sv
`default_nettype none

package ddnc_pkg;

    // field widths
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned YEAR_W   = 14;
    localparam int unsigned COUNT_W  = 22;
    localparam int unsigned WDAY_W   = 3;

    // stream packing
    localparam int unsigned IN_DATA_W  = 48;
    localparam int unsigned OUT_DATA_W = 48;
    localparam int unsigned OUT_USER_W = 2;

    // function select
    localparam logic FUNC_TO_COUNT = 1'b0;
    localparam logic FUNC_TO_DATE  = 1'b1;

    // calendar constants
    localparam int unsigned DAY_OFFSET = 443;
    localparam int unsigned YEAR_LOW   = 100;
    localparam int unsigned YEAR_HIGH  = 9999;
    localparam int unsigned LATE_MONTH = 2;     // months above this keep their year
    localparam int unsigned MONTH_ADD_LATE  = 1;
    localparam int unsigned MONTH_ADD_EARLY = 13;
    localparam int unsigned MIDX_WRAP  = 14;    // month index where the year rolls
    localparam int unsigned MIDX_MAX   = 15;    // largest month index a day count can give

    // internal widths
    localparam int unsigned MIDX_W   = 5;       // month index 0..16
    localparam int unsigned MDAYS_W  = 9;       // floor(30.6001*m) up to 489
    localparam int unsigned REM_W    = 9;       // days left after whole years, 123..488
    localparam int unsigned DAYNO_W  = 23;      // count + offset
    localparam int unsigned YDAYS_W  = 23;      // floor(365.25*y)
    localparam int unsigned QDAY_W   = 11;
    localparam int unsigned YPROD_W  = YDAYS_W + 2;
    localparam logic [QDAY_W-1:0] QUARTER_DAYS = 11'd1461;

    // floor((20*dayno - 2442) / 7305) by reciprocal, exact for 27-bit numerators
    localparam int unsigned SCALED_W   = 27;
    localparam int unsigned RECIP_W    = 28;
    localparam int unsigned YEAR_SHIFT = 40;
    localparam int unsigned DPROD_W    = SCALED_W + RECIP_W;
    localparam logic [RECIP_W-1:0]  YEAR_RECIP = 28'd150514939;
    localparam logic [SCALED_W-1:0] YEAR_BIAS  = 27'd2442;

    // mod 7 by octal digit folding (8 is 1 mod 7)
    localparam int unsigned MOD_GROUPS = (COUNT_W + 2) / 3;
    localparam int unsigned MOD_SUM_W  = 6;

    typedef struct packed {
        logic               func;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [YEAR_W-1:0]  year;
        logic [COUNT_W-1:0] count;
    } t_item;

    typedef struct packed {
        t_item              item;
        logic               is_null;
        logic               out_range;
        logic [MIDX_W-1:0]  midx;
        logic [YDAYS_W-1:0] ydays;
        logic [YEAR_W-1:0]  year_est;
    } t_stage1;

    typedef struct packed {
        t_item              item;
        logic               is_null;
        logic               out_range;
        logic [COUNT_W-1:0] count_calc;
        logic [YEAR_W-1:0]  year_est;
        logic [YDAYS_W-1:0] ydays_est;
    } t_stage2;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [YEAR_W-1:0]  year;
        logic [WDAY_W-1:0]  weekday;
        logic               is_null;
        logic               in_range;
    } t_result;

    // floor(30.6001*m)
    function automatic logic [MDAYS_W-1:0] fn_month_days(input logic [MIDX_W-1:0] m);
        logic [MDAYS_W-1:0] v;
        case (m)
            5'd1:    v = 9'd30;
            5'd2:    v = 9'd61;
            5'd3:    v = 9'd91;
            5'd4:    v = 9'd122;
            5'd5:    v = 9'd153;
            5'd6:    v = 9'd183;
            5'd7:    v = 9'd214;
            5'd8:    v = 9'd244;
            5'd9:    v = 9'd275;
            5'd10:   v = 9'd306;
            5'd11:   v = 9'd336;
            5'd12:   v = 9'd367;
            5'd13:   v = 9'd397;
            5'd14:   v = 9'd428;
            5'd15:   v = 9'd459;
            5'd16:   v = 9'd489;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [WDAY_W-1:0] fn_mod7(input logic [COUNT_W-1:0] v);
        logic [3*MOD_GROUPS-1:0] w;
        logic [MOD_SUM_W-1:0]    s1;
        logic [3:0]              s2;
        logic [2:0]              s3;
        w  = (3*MOD_GROUPS)'(v);
        s1 = '0;
        for (int i = 0; i < MOD_GROUPS; i++) begin
            s1 = s1 + MOD_SUM_W'(w[3*i +: 3]);
        end
        s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
        s3 = s2[2:0] + 3'(s2[3]);
        return (s3 == 3'd7) ? '0 : s3;
    endfunction

endpackage

`default_nettype wire

// File: design/date_day_number_converter.sv
// date / day-count converter, julian-calendar day numbers offset by 443
// throughput: one request per cycle while the result side is ready, through the four-register
// pipeline (input, two multiply stages, result); bubbles collapse so requests keep entering during
// output stalls until every stage holds one; reset: synchronous active-low i_rst_n clears the stage valid bits only
`default_nettype none

module date_day_number_converter (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // request side
    input  wire                                i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // month[3:0], day[8:4], year[22:9], count[44:23], zero pad[47:45]
    input  wire  [ddnc_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // func[0]
    input  wire  [0:0]                         i_s_axis_tuser,
    // result side
    output logic                               o_m_axis_tvalid,
    input  wire                                i_m_axis_tready,
    // count[21:0], month[25:22], day[30:26], year[44:31], weekday[47:45]
    output logic [ddnc_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    // is_null[0], in_range[1]
    output logic [ddnc_pkg::OUT_USER_W-1:0]    o_m_axis_tuser
);

    import ddnc_pkg::*;

    localparam int unsigned NSTAGE = 4;

    // pipeline control: stage k loads when empty or when it hands off downstream
    logic [NSTAGE-1:0] r_vld;
    logic [NSTAGE-1:0] n_vld;
    logic [NSTAGE:0]   en;

    t_item   r_s0, n_s0;
    t_stage1 r_s1, n_s1;
    t_stage2 r_s2, n_s2;
    t_result r_res, n_res;

    always_comb begin
        en[NSTAGE] = i_m_axis_tready;
        for (int k = NSTAGE - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_comb begin
        n_vld[0] = en[0] ? i_s_axis_tvalid : r_vld[0];
        for (int k = 1; k < NSTAGE; k++) begin
            n_vld[k] = en[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // unpack the request
    always_comb begin
        n_s0.func  = i_s_axis_tuser[0];
        n_s0.month = i_s_axis_tdata[3:0];
        n_s0.day   = i_s_axis_tdata[8:4];
        n_s0.year  = i_s_axis_tdata[22:9];
        n_s0.count = i_s_axis_tdata[44:23];
    end

    // stage 1: null / range check, month shift, 365.25*y and the year estimate multiply
    logic [YEAR_W-1:0]   s1_yy;
    logic [YPROD_W-1:0]  s1_yprod;
    logic [DAYNO_W-1:0]  s1_dayno;
    logic [SCALED_W-1:0] s1_scaled;
    logic [DPROD_W-1:0]  s1_dprod;

    always_comb begin
        n_s1.item      = r_s0;
        n_s1.is_null   = (r_s0.month == '0) && (r_s0.day == '0) && (r_s0.year == '0);
        n_s1.out_range = (r_s0.year < YEAR_W'(YEAR_LOW)) || (r_s0.year > YEAR_W'(YEAR_HIGH));

        // jan and feb count as months 13 and 14 of the previous year
        if (r_s0.month > MONTH_W'(LATE_MONTH)) begin
            n_s1.midx = MIDX_W'(r_s0.month) + MIDX_W'(MONTH_ADD_LATE);
            s1_yy     = r_s0.year;
        end else begin
            n_s1.midx = MIDX_W'(r_s0.month) + MIDX_W'(MONTH_ADD_EARLY);
            s1_yy     = r_s0.year - YEAR_W'(1);
        end
        s1_yprod   = YPROD_W'(QUARTER_DAYS) * YPROD_W'(s1_yy);
        n_s1.ydays = s1_yprod[YPROD_W-1:2];

        // 20*dayno - 2442, then divide by 7305 through the reciprocal
        s1_dayno  = DAYNO_W'(r_s0.count) + DAYNO_W'(DAY_OFFSET);
        s1_scaled = (SCALED_W'(s1_dayno) << 4) + (SCALED_W'(s1_dayno) << 2) - YEAR_BIAS;
        s1_dprod  = DPROD_W'(s1_scaled) * DPROD_W'(YEAR_RECIP);
        n_s1.year_est = s1_dprod[YEAR_SHIFT +: YEAR_W];
    end

    // stage 2: date to count sum, whole-year days of the estimated year
    logic [DAYNO_W-1:0] s2_sum;
    logic [YPROD_W-1:0] s2_yprod;

    always_comb begin
        n_s2.item      = r_s1.item;
        n_s2.is_null   = r_s1.is_null;
        n_s2.out_range = r_s1.out_range;
        n_s2.year_est  = r_s1.year_est;

        s2_sum = DAYNO_W'(r_s1.ydays) + DAYNO_W'(fn_month_days(r_s1.midx))
               + DAYNO_W'(r_s1.item.day) - DAYNO_W'(DAY_OFFSET);
        n_s2.count_calc = s2_sum[COUNT_W-1:0];

        s2_yprod       = YPROD_W'(QUARTER_DAYS) * YPROD_W'(r_s1.year_est);
        n_s2.ydays_est = s2_yprod[YPROD_W-1:2];
    end

    // stage 3: month and day from the remainder, weekday, result select
    logic [DAYNO_W-1:0] s3_dayno;
    logic [DAYNO_W-1:0] s3_diff;
    logic [REM_W-1:0]   s3_rem;
    logic [MIDX_W-1:0]  s3_midx;
    logic [MDAYS_W-1:0] s3_dd;
    logic               s3_wrap;
    logic [YEAR_W-1:0]  s3_year;

    always_comb begin
        s3_dayno = DAYNO_W'(r_s2.item.count) + DAYNO_W'(DAY_OFFSET);
        s3_diff  = s3_dayno - r_s2.ydays_est;
        s3_rem   = s3_diff[REM_W-1:0];

        // month index is the number of month starts the remainder has passed
        s3_midx = '0;
        for (int k = 1; k <= MIDX_MAX; k++) begin
            if (s3_rem > fn_month_days(MIDX_W'(k))) begin
                s3_midx = s3_midx + MIDX_W'(1);
            end
        end
        s3_dd   = s3_rem - fn_month_days(s3_midx);
        s3_wrap = (s3_midx >= MIDX_W'(MIDX_WRAP));
        s3_year = r_s2.year_est + YEAR_W'(s3_wrap);

        n_res = '0;
        n_res.in_range = 1'b1;
        if (r_s2.item.func == FUNC_TO_COUNT) begin
            n_res.month = r_s2.item.month;
            n_res.day   = r_s2.item.day;
            n_res.year  = r_s2.item.year;
            if (r_s2.is_null) begin
                n_res.is_null = 1'b1;
            end else if (r_s2.out_range) begin
                n_res.in_range = 1'b0;
            end else begin
                n_res.count   = r_s2.count_calc;
                n_res.weekday = fn_mod7(r_s2.count_calc);
            end
        end else begin
            n_res.count = r_s2.item.count;
            if (r_s2.item.count == '0) begin
                n_res.is_null = 1'b1;
            end else begin
                n_res.month    = s3_wrap ? MONTH_W'(s3_midx - MIDX_W'(MONTH_ADD_EARLY))
                                         : MONTH_W'(s3_midx - MIDX_W'(MONTH_ADD_LATE));
                n_res.day      = s3_dd[DAY_W-1:0];
                n_res.year     = s3_year;
                n_res.weekday  = fn_mod7(r_s2.item.count);
                n_res.in_range = (s3_year >= YEAR_W'(YEAR_LOW))
                              && (s3_year <= YEAR_W'(YEAR_HIGH));
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_s0 <= n_s0;
        end
        if (en[1]) begin
            r_s1 <= n_s1;
        end
        if (en[2]) begin
            r_s2 <= n_s2;
        end
        if (en[3]) begin
            r_res <= n_res;
        end
    end

    assign o_s_axis_tready = en[0];
    assign o_m_axis_tvalid = r_vld[NSTAGE-1];
    assign o_m_axis_tdata  = {r_res.weekday, r_res.year, r_res.day, r_res.month, r_res.count};
    assign o_m_axis_tuser  = {r_res.in_range, r_res.is_null};

`ifndef ASSERT_OFF
    // requests are refused only when every stage holds an item
    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_vld == '1))
        else $error("request refused with a free pipeline stage");

    // a taken result is replaced by what stood in the stage before it
    a_output_refill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NSTAGE-1] && i_m_axis_tready) |=> (r_vld[NSTAGE-1] == $past(r_vld[NSTAGE-2])))
        else $error("result stage lost or duplicated an item");

    // null results carry a zero count and weekday and are always in range
    a_null_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && r_res.is_null) |->
            (r_res.count == '0 && r_res.weekday == '0 && r_res.in_range))
        else $error("null result with stray fields");

    a_weekday_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_res.weekday != 3'd7))
        else $error("weekday out of range");
`endif

endmodule

`default_nettype wire
